// ===== hw/rtl/nfa_pkg.sv =====
// Shared types and codes of the next-fit heap allocator.
// Holds the header layout, request and result records and the sequencer states.
// No dependencies.
package nfa_pkg;

  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_FREE   = 2'd1;
  localparam logic [1:0] ACT_RESIZE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  // One block header as it sits in the header memory.
  typedef struct packed {
    logic        used;
    logic [15:0] size;
    logic [15:0] prev;
    logic [15:0] next;
  } hdr_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] block_address;
    logic [15:0] request_size;
  } item_t;

  typedef struct packed {
    logic [15:0] result_address;
    logic [1:0]  status;
    logic        copy_needed;
    logic [15:0] copy_source;
    logic [15:0] copy_length;
  } result_t;

  // Access to the header memory, addressed by byte offset.
  typedef struct packed {
    logic        we;
    logic [15:0] waddr;
    hdr_t        wdata;
    logic [15:0] raddr;
  } mem_req_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DISP,
    S_AL0, S_AL_INIT, S_AW, S_AF, S_AG0, S_AG1, S_AG2, S_AG3, S_AL_END, S_FB,
    S_FIND0, S_FIND1, S_FIND2,
    S_RL0, S_RL1, S_RL2, S_RL3, S_RL4, S_RL_END,
    S_RZ0, S_RZ1, S_RZ2, S_RZ3, S_MB0, S_MP0, S_MP1, S_NX0, S_NX1,
    S_JP0, S_JP1, S_JP2, S_JP3,
    S_JN0, S_JN1, S_JN2, S_JN3,
    S_SP0, S_SP1, S_SP2, S_SP3,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/nfa_req_if.sv =====
// Request channel of the heap allocator: valid, ready and one request item.
// Depends on nothing.
interface nfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] block_address;
  logic [15:0] request_size;

  modport source (output valid, action, block_address, request_size, input ready);
  modport sink (input valid, action, block_address, request_size, output ready);
endinterface

// ===== hw/rtl/nfa_rsp_if.sv =====
// Response channel of the heap allocator: valid, ready and one result item.
// Depends on nothing.
interface nfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_address;
  logic [1:0]  status;
  logic        copy_needed;
  logic [15:0] copy_source;
  logic [15:0] copy_length;

  modport source (output valid, result_address, status, copy_needed, copy_source,
                  copy_length, input ready);
  modport sink (input valid, result_address, status, copy_needed, copy_source,
                copy_length, output ready);
endinterface

// ===== hw/rtl/nfa_hdr_ram.sv =====
// Header memory: one write port, one read port with registered read data.
// A read of the entry written in the same cycle returns the new header.
// Depends on nfa_pkg.
module nfa_hdr_ram #(
  parameter int DEPTH = 16384
) (
  input  logic              clk,
  input  nfa_pkg::mem_req_t mem_req,
  output nfa_pkg::hdr_t     rdata
);
  import nfa_pkg::*;

  localparam int AW = $clog2(DEPTH);

  hdr_t          mem [DEPTH];
  logic [AW-1:0] widx;
  logic [AW-1:0] ridx;

  assign widx = mem_req.waddr[AW+1:2];
  assign ridx = mem_req.raddr[AW+1:2];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[widx] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.we && (widx == ridx)) begin
      rdata <= mem_req.wdata;
    end else begin
      rdata <= mem[ridx];
    end
  end
endmodule

// ===== hw/rtl/nfa_ctrl.sv =====
// Sequencer of the heap allocator: walks the header chain and rewrites headers.
// Every header access goes through the header memory, one read and one write a cycle.
// Depends on nfa_pkg.
module nfa_ctrl #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  nfa_pkg::item_t    item,
  output logic              item_ready,
  output logic              res_valid,
  output nfa_pkg::result_t  res_out,
  input  logic              res_ready,
  input  logic [16:0]       eff_limit,
  output nfa_pkg::mem_req_t mem_req,
  input  nfa_pkg::hdr_t     mem_rdata
);
  import nfa_pkg::*;

  localparam int WALK_BOUND = HEAP_BYTES / HEADER_BYTES + 4;
  localparam int KW = $clog2(WALK_BOUND + 1);
  localparam logic [15:0] H16 = 16'(HEADER_BYTES);
  localparam logic [15:0] H2_16 = 16'(2 * HEADER_BYTES);
  localparam logic [17:0] H18 = 18'(HEADER_BYTES);
  localparam logic [17:0] H2_18 = 18'(2 * HEADER_BYTES);
  localparam logic [17:0] SPLIT_MIN = 18'(HEADER_BYTES + 4);
  localparam logic [KW:0] KMAX = (KW + 1)'(WALK_BOUND);

  state_t        state, state_next, ret, ret_next;
  logic [1:0]    act, act_next;
  logic [15:0]   addr, addr_next, req, req_next;
  logic [16:0]   rnd, rnd_next;
  logic [15:0]   cur, cur_next;
  logic [KW-1:0] k, k_next;
  hdr_t          hc, hc_next, hp, hp_next;
  logic [15:0]   jx, jx_next, sw, sw_next, tmp, tmp_next;
  logic [15:0]   old, old_next, pv, pv_next, ab, ab_next, hb, hb_next;
  logic [15:0]   res, res_next, src, src_next, len, len_next;
  logic [1:0]    st, st_next;
  logic          cp, cp_next, fb, fb_next;
  logic [15:0]   rover, rover_next, last, last_next;
  logic [16:0]   heap_end, heap_end_next;
  logic          started, started_next;

  logic [17:0]   new_end;
  logic [15:0]   nt, nw;
  logic [17:0]   sum_p, sum_n, sum_b;
  logic [16:0]   fit_diff;
  logic [KW:0]   k_inc;

  // True when a block of this size, trimmed to want bytes, leaves room for
  // another header and data (wraps like an unsigned subtraction).
  function automatic logic split_ok(input logic [15:0] size, input logic [16:0] want);
    logic [17:0] d;
    d = {2'b00, size} - {1'b0, want};
    return d[17] || (d >= SPLIT_MIN);
  endfunction

  function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
    return (a < b) ? a : b;
  endfunction

  assign new_end  = {1'b0, heap_end} + H18 + {1'b0, rnd};
  assign nt       = last + H16 + rnd[15:0];
  assign nw       = jx + H16 + sw;
  assign sum_p    = 18'(hc.size) + H18 + 18'(hp.size);
  assign sum_n    = 18'(hc.size) + H18 + 18'(mem_rdata.size);
  assign sum_b    = 18'(hc.size) + 18'(hp.size) + 18'(mem_rdata.size) + H2_18;
  assign fit_diff = {1'b0, mem_rdata.size} - rnd;
  assign k_inc    = {1'b0, k} + 1'b1;

  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res_out    = '{result_address: res, status: st, copy_needed: cp,
                        copy_source: src, copy_length: len};

  always_comb begin
    state_next = state;      ret_next = ret;
    act_next = act;          addr_next = addr;       req_next = req;
    rnd_next = rnd;          cur_next = cur;         k_next = k;
    hc_next = hc;            hp_next = hp;           jx_next = jx;
    sw_next = sw;            tmp_next = tmp;         old_next = old;
    pv_next = pv;            ab_next = ab;           hb_next = hb;
    res_next = res;          src_next = src;         len_next = len;
    st_next = st;            cp_next = cp;           fb_next = fb;
    rover_next = rover;      last_next = last;
    heap_end_next = heap_end;
    started_next = started;
    mem_req = '0;

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          act_next  = item.action;
          addr_next = item.block_address;
          req_next  = item.request_size;
          rnd_next  = (17'(item.request_size) + 17'd3) & ~17'd3;
          res_next  = '0;
          st_next   = ST_NULL;
          cp_next   = 1'b0;
          src_next  = '0;
          len_next  = '0;
          fb_next   = 1'b0;
          state_next = S_DISP;
        end
      end

      S_DISP: begin
        case (act)
          ACT_ALLOC:  state_next = (rnd == '0) ? S_DONE : S_AL0;
          ACT_FREE:   state_next = S_FIND0;
          ACT_RESIZE: begin
            if (addr == '0) begin
              state_next = (req != '0) ? S_AL0 : S_DONE;
            end else begin
              state_next = S_FIND0;
            end
          end
          default:    state_next = S_DONE;
        endcase
      end

      // ---------------- allocate ----------------
      S_AL0: begin
        if (!started) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = '{used: 1'b1, size: '0, prev: H16, next: H16};
          state_next    = S_AL_INIT;
        end else begin
          mem_req.raddr = rover;
          cur_next      = rover;
          k_next        = '0;
          state_next    = S_AW;
        end
      end

      S_AL_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = H16;
        mem_req.wdata = '{used: 1'b1, size: '0, prev: '0, next: '0};
        rover_next    = '0;
        last_next     = H16;
        heap_end_next = 17'(H2_16);
        started_next  = 1'b1;
        state_next    = S_AL0;
      end

      S_AW: begin
        if (!mem_rdata.used && ({1'b0, mem_rdata.size} >= rnd)) begin
          hc_next            = mem_rdata;
          mem_req.we         = 1'b1;
          mem_req.waddr      = cur;
          mem_req.wdata      = mem_rdata;
          mem_req.wdata.used = 1'b1;
          if (fit_diff > 17'(SPLIT_MIN)) begin
            jx_next    = cur;
            sw_next    = rnd[15:0];
            ret_next   = S_AF;
            state_next = S_SP0;
          end else begin
            state_next = S_AF;
          end
        end else if ((mem_rdata.next == rover) || (k_inc >= KMAX)) begin
          state_next = S_AG0;
        end else begin
          cur_next      = mem_rdata.next;
          k_next        = k_inc[KW-1:0];
          mem_req.raddr = mem_rdata.next;
        end
      end

      S_AF: begin
        rover_next = cur;
        ab_next    = cur;
        st_next    = ST_OK;
        state_next = S_AL_END;
      end

      S_AG0: begin
        if (new_end > {1'b0, eff_limit}) begin
          st_next    = ST_OOM;
          state_next = S_AL_END;
        end else begin
          mem_req.raddr = last;
          state_next    = S_AG1;
        end
      end

      S_AG1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = last;
        mem_req.wdata = '{used: 1'b1, size: rnd[15:0], prev: mem_rdata.prev, next: nt};
        state_next    = S_AG2;
      end

      S_AG2: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = nt;
        mem_req.wdata = '{used: 1'b1, size: '0, prev: last, next: '0};
        mem_req.raddr = '0;
        state_next    = S_AG3;
      end

      S_AG3: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = '0;
        mem_req.wdata      = mem_rdata;
        mem_req.wdata.prev = nt;
        ab_next            = last;
        last_next          = nt;
        heap_end_next      = new_end[16:0];
        st_next            = ST_OK;
        state_next         = S_AL_END;
      end

      S_AL_END: begin
        if (!fb) begin
          if (st == ST_OK) begin
            res_next = ab + H16;
          end
          state_next = S_DONE;
        end else if (st == ST_OK) begin
          mem_req.raddr = ab;
          state_next    = S_FB;
        end else begin
          state_next = S_DONE;
        end
      end

      S_FB: begin
        len_next   = min16(old, mem_rdata.size);
        cp_next    = 1'b1;
        src_next   = addr;
        state_next = S_RL0;
      end

      // ---------------- look up a used block ----------------
      S_FIND0: begin
        hb_next = addr - H16;
        if (!started || (addr < H2_16)) begin
          state_next = S_DONE;
        end else begin
          mem_req.raddr = '0;
          state_next    = S_FIND1;
        end
      end

      S_FIND1: begin
        if ((mem_rdata.next == last) || (mem_rdata.next == '0)) begin
          state_next = S_DONE;
        end else begin
          cur_next      = mem_rdata.next;
          k_next        = '0;
          mem_req.raddr = mem_rdata.next;
          state_next    = S_FIND2;
        end
      end

      S_FIND2: begin
        if (cur == hb) begin
          if (!mem_rdata.used) begin
            state_next = S_DONE;
          end else begin
            state_next = (act == ACT_FREE) ? S_RL0 : S_RZ0;
          end
        end else if ((k_inc >= KMAX) || (mem_rdata.next == last) ||
                     (mem_rdata.next == '0)) begin
          state_next = S_DONE;
        end else begin
          cur_next      = mem_rdata.next;
          k_next        = k_inc[KW-1:0];
          mem_req.raddr = mem_rdata.next;
        end
      end

      // ---------------- release block hb ----------------
      S_RL0: begin
        mem_req.raddr = hb;
        state_next    = S_RL1;
      end

      S_RL1: begin
        hc_next       = mem_rdata;
        mem_req.raddr = mem_rdata.prev;
        state_next    = S_RL2;
      end

      S_RL2: begin
        hp_next       = mem_rdata;
        mem_req.raddr = hc.next;
        state_next    = S_RL3;
      end

      S_RL3: begin
        jx_next = hb;
        if (hp.used && mem_rdata.used) begin
          mem_req.we         = 1'b1;
          mem_req.waddr      = hb;
          mem_req.wdata      = hc;
          mem_req.wdata.used = 1'b0;
          state_next         = S_RL_END;
        end else if (!hp.used && mem_rdata.used) begin
          rover_next = hc.prev;
          ret_next   = S_RL_END;
          state_next = S_JP0;
        end else if (hp.used) begin
          mem_req.we         = 1'b1;
          mem_req.waddr      = hb;
          mem_req.wdata      = hc;
          mem_req.wdata.used = 1'b0;
          rover_next         = hb;
          ret_next           = S_RL_END;
          state_next         = S_JN0;
        end else begin
          rover_next = hc.prev;
          ret_next   = S_RL4;
          state_next = S_JN0;
        end
      end

      S_RL4: begin
        jx_next    = hb;
        ret_next   = S_RL_END;
        state_next = S_JP0;
      end

      S_RL_END: begin
        st_next = ST_OK;
        if (fb) begin
          rover_next = ab;
          res_next   = ab + H16;
        end
        state_next = S_DONE;
      end

      // ---------------- resize ----------------
      S_RZ0: begin
        mem_req.raddr = hb;
        state_next    = S_RZ1;
      end

      S_RZ1: begin
        hc_next       = mem_rdata;
        old_next      = mem_rdata.size;
        pv_next       = mem_rdata.prev;
        mem_req.raddr = mem_rdata.prev;
        state_next    = S_RZ2;
      end

      S_RZ2: begin
        hp_next       = mem_rdata;
        mem_req.raddr = hc.next;
        state_next    = S_RZ3;
      end

      S_RZ3: begin
        jx_next = hb;
        if (req == '0) begin
          state_next = S_RL0;
        end else if ({1'b0, hc.size} >= rnd) begin
          res_next = addr;
          st_next  = ST_OK;
          if (split_ok(hc.size, rnd)) begin
            sw_next    = rnd[15:0];
            rover_next = hb;
            ret_next   = S_DONE;
            state_next = S_SP0;
          end else begin
            state_next = S_DONE;
          end
        end else if (!hp.used && mem_rdata.used && (sum_p >= {1'b0, rnd})) begin
          ret_next   = S_MP0;
          state_next = S_JP0;
        end else if (hp.used && !mem_rdata.used && (sum_n >= {1'b0, rnd})) begin
          ret_next   = S_NX0;
          state_next = S_JN0;
        end else if (!hp.used && !mem_rdata.used && (sum_b >= {1'b0, rnd})) begin
          ret_next   = S_MB0;
          state_next = S_JN0;
        end else begin
          fb_next    = 1'b1;
          state_next = S_AL0;
        end
      end

      S_MB0: begin
        jx_next    = hb;
        ret_next   = S_MP0;
        state_next = S_JP0;
      end

      S_MP0: begin
        mem_req.raddr = pv;
        state_next    = S_MP1;
      end

      // The data moves down into the previous block, which is marked used.
      S_MP1: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = pv;
        mem_req.wdata      = mem_rdata;
        mem_req.wdata.used = 1'b1;
        rover_next         = pv;
        res_next           = pv + H16;
        st_next            = ST_OK;
        cp_next            = 1'b1;
        src_next           = addr;
        if (split_ok(mem_rdata.size, rnd)) begin
          len_next   = min16(old, rnd[15:0]);
          jx_next    = pv;
          sw_next    = rnd[15:0];
          ret_next   = S_DONE;
          state_next = S_SP0;
        end else begin
          len_next   = min16(old, mem_rdata.size);
          state_next = S_DONE;
        end
      end

      S_NX0: begin
        mem_req.raddr = hb;
        state_next    = S_NX1;
      end

      S_NX1: begin
        rover_next = hb;
        res_next   = addr;
        st_next    = ST_OK;
        if (split_ok(mem_rdata.size, rnd)) begin
          jx_next    = hb;
          sw_next    = rnd[15:0];
          ret_next   = S_DONE;
          state_next = S_SP0;
        end else begin
          state_next = S_DONE;
        end
      end

      // ---------------- join jx into its previous block ----------------
      S_JP0: begin
        mem_req.raddr = jx;
        state_next    = S_JP1;
      end

      S_JP1: begin
        hc_next       = mem_rdata;
        mem_req.raddr = mem_rdata.prev;
        state_next    = S_JP2;
      end

      S_JP2: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = hc.prev;
        mem_req.wdata = '{used: mem_rdata.used, size: mem_rdata.size + hc.size + H16,
                          prev: mem_rdata.prev, next: hc.next};
        mem_req.raddr = hc.next;
        state_next    = S_JP3;
      end

      S_JP3: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = hc.next;
        mem_req.wdata      = mem_rdata;
        mem_req.wdata.prev = hc.prev;
        state_next         = ret;
      end

      // ---------------- join the next block into jx ----------------
      S_JN0: begin
        mem_req.raddr = jx;
        state_next    = S_JN1;
      end

      S_JN1: begin
        hc_next       = mem_rdata;
        mem_req.raddr = mem_rdata.next;
        state_next    = S_JN2;
      end

      S_JN2: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = jx;
        mem_req.wdata = '{used: hc.used, size: hc.size + mem_rdata.size + H16,
                          prev: hc.prev, next: mem_rdata.next};
        tmp_next      = mem_rdata.next;
        mem_req.raddr = mem_rdata.next;
        state_next    = S_JN3;
      end

      S_JN3: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = tmp;
        mem_req.wdata      = mem_rdata;
        mem_req.wdata.prev = jx;
        state_next         = ret;
      end

      // ---------------- split jx after sw data bytes ----------------
      S_SP0: begin
        mem_req.raddr = jx;
        state_next    = S_SP1;
      end

      S_SP1: begin
        hc_next       = mem_rdata;
        mem_req.we    = 1'b1;
        mem_req.waddr = nw;
        mem_req.wdata = '{used: 1'b0, size: mem_rdata.size - sw - H16,
                          prev: jx, next: mem_rdata.next};
        mem_req.raddr = mem_rdata.next;
        state_next    = S_SP2;
      end

      S_SP2: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = hc.next;
        mem_req.wdata      = mem_rdata;
        mem_req.wdata.prev = nw;
        state_next         = S_SP3;
      end

      S_SP3: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = jx;
        mem_req.wdata = '{used: hc.used, size: sw, prev: hc.prev, next: nw};
        state_next    = ret;
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      rover    <= '0;
      last     <= H16;
      heap_end <= 17'(H2_16);
      started  <= 1'b0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      rover    <= rover_next;
      last     <= last_next;
      heap_end <= heap_end_next;
      started  <= started_next;
    end
  end

  always_ff @(posedge clk) begin
    act  <= act_next;   addr <= addr_next;  req <= req_next;
    rnd  <= rnd_next;   cur  <= cur_next;   k   <= k_next;
    hc   <= hc_next;    hp   <= hp_next;    jx  <= jx_next;
    sw   <= sw_next;    tmp  <= tmp_next;   old <= old_next;
    pv   <= pv_next;    ab   <= ab_next;    hb  <= hb_next;
    res  <= res_next;   src  <= src_next;   len <= len_next;
    st   <= st_next;    cp   <= cp_next;    fb  <= fb_next;
  end
endmodule

// ===== hw/rtl/next_fit_heap_allocator.sv =====
// Next-fit heap allocator with coalescing over an address-ordered chain of headers.
// Top level: configuration register, result register, sequencer and header memory.
// Depends on nfa_pkg, nfa_req_if, nfa_rsp_if, nfa_hdr_ram and nfa_ctrl.
//
// Usage: each transfer on the request channel asks to allocate, free or resize a
// block; exactly one transfer on the response channel answers it, in order.
// heap_limit caps the heap end in bytes and is written through heap_limit_we/
// heap_limit_wdata; the user must do so only while idle, as the block has no check.
// The block works on one request at a time. An allocate walks the headers from the
// rover and may split the block it finds or grow the heap; the very first allocate
// also writes the initial headers. A free looks up the block and may join it with
// one or both neighbours; a resize in place may split the block or merge it with
// one or both neighbours; a resize that must move the data adds an allocate and a
// free. The sequencer returns to idle before it takes the next request. Every
// header goes through the single read port of the header memory.
// Reset empties the heap at once; the header memory needs no clearing pass,
// since only headers written since reset are ever read.
// The finished result sits in an output register, so a new request is taken
// while the receiver stalls; the sequencer then waits with its next result.
module next_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        heap_limit_we,
  input  logic [16:0] heap_limit_wdata,
  nfa_req_if.sink     request,
  nfa_rsp_if.source   response
);
  import nfa_pkg::*;

  // Offsets are 16 bits, so the store never covers more than 64 KiB.
  localparam int CAP_BYTES = (HEAP_BYTES > 65536) ? 65536 : HEAP_BYTES;
  localparam int DEPTH = CAP_BYTES / 4;

  logic [16:0] heap_limit;
  logic [16:0] eff_limit;
  item_t       item;
  result_t     ctrl_res;
  result_t     out_res;
  logic        ctrl_res_valid;
  logic        ctrl_res_ready;
  logic        out_valid;
  mem_req_t    mem_req;
  hdr_t        mem_rdata;

  // Configuration register; the effective limit never exceeds the heap itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= 17'h10000;
    end else if (heap_limit_we) begin
      heap_limit <= heap_limit_wdata;
    end
  end

  assign eff_limit = (heap_limit > 17'(CAP_BYTES)) ? 17'(CAP_BYTES) : heap_limit;

  assign item = '{action: request.action, block_address: request.block_address,
                  request_size: request.request_size};

  nfa_ctrl #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (request.valid),
    .item       (item),
    .item_ready (request.ready),
    .res_valid  (ctrl_res_valid),
    .res_out    (ctrl_res),
    .res_ready  (ctrl_res_ready),
    .eff_limit  (eff_limit),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  nfa_hdr_ram #(
    .DEPTH (DEPTH)
  ) u_hdr_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

  // Output register: it takes a new result when empty or being drained this cycle.
  assign ctrl_res_ready = !out_valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_res_valid && ctrl_res_ready) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_res_valid && ctrl_res_ready) begin
      out_res <= ctrl_res;
    end
  end

  assign response.valid          = out_valid;
  assign response.result_address = out_res.result_address;
  assign response.status         = out_res.status;
  assign response.copy_needed    = out_res.copy_needed;
  assign response.copy_source    = out_res.copy_source;
  assign response.copy_length    = out_res.copy_length;

  // The sequencer handles one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> !request.ready)
    else $error("request taken while another is in progress");

  // A copy is only ever requested for a successful move to a real block.
  a_copy_ok: assert property (@(posedge clk) disable iff (rst)
    response.valid && response.copy_needed |->
      response.status == ST_OK && response.result_address != 16'd0)
    else $error("copy requested without a successful move");

  // A failed or empty request never hands back an address.
  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    response.valid && response.status != ST_OK |->
      response.result_address == 16'd0 && !response.copy_needed)
    else $error("failed request returned an address");
endmodule
